@@ hdl/cdc_pkg.sv @@
// Package for the calendar date counter: opcodes, controller states,
// command/status structs and the month-length lookup.
// No dependencies.
package cdc_pkg;

    localparam logic OP_ADVANCE = 1'b0;
    localparam logic OP_LOAD    = 1'b1;

    localparam logic [3:0] MONTH_FIRST = 4'd1;
    localparam logic [3:0] MONTH_FEB   = 4'd2;
    localparam logic [3:0] MONTHS      = 4'd12;
    localparam logic [4:0] DAY_FIRST   = 5'd1;
    localparam logic [4:0] LEAP_FEB    = 5'd29;
    localparam logic [4:0] LONG_MONTH  = 5'd31;

    // year mod 100 tracking
    localparam logic [7:0] CENTURY     = 8'd100;
    localparam logic [6:0] CENT_LAST   = 7'd99;

    // year / 100 for any 32-bit year: (year * DIV100_MAGIC) >> DIV100_SHIFT
    localparam logic [31:0] DIV100_MAGIC = 32'h51EB851F;
    localparam int          DIV100_SHIFT = 37;

    // reset date 1/1/2000: 2000 mod 100 = 0, (2000/100) mod 4 = 0
    localparam int         YEAR_RESET  = 2000;
    localparam logic [6:0] MOD_RESET   = 7'd0;
    localparam logic [1:0] CENT_RESET  = 2'd0;

    localparam logic [4:0] MONTH_LEN [13] = '{
        5'd31, 5'd31, 5'd28, 5'd31, 5'd30, 5'd31, 5'd30,
        5'd31, 5'd31, 5'd30, 5'd31, 5'd30, 5'd31
    };

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_DIV,
        ST_CLAMP,
        ST_ADV,
        ST_DONE
    } t_state;

    typedef struct packed {
        logic ld_accept;
        logic adv_accept;
        logic div_step;
        logic clamp;
        logic adv_step;
        logic capture;
    } t_cmd;

    typedef struct packed {
        logic div_last;
        logic cnt_zero;
        logic out_free;
    } t_status;

    function automatic logic [4:0] days_in(input logic [3:0] m, input logic leap);
        logic [4:0] d;
        if (m > MONTHS) begin
            d = LONG_MONTH;
        end else if (m == MONTH_FEB && leap) begin
            d = LEAP_FEB;
        end else begin
            d = MONTH_LEN[m];
        end
        return d;
    endfunction

endpackage

@@ hdl/cdc_if.sv @@
// Valid/ready channel interfaces for the calendar date counter:
// command words in, date words out. No dependencies.
interface cdc_in_if;
    logic        valid;
    logic        ready;
    logic        opcode;
    logic [7:0]  load_day;
    logic [7:0]  load_month;
    logic [15:0] load_year;
    logic [9:0]  day_count;

    modport source (output valid, opcode, load_day, load_month, load_year, day_count,
                    input ready);
    modport sink   (input valid, opcode, load_day, load_month, load_year, day_count,
                    output ready);
endinterface

interface cdc_out_if;
    logic        valid;
    logic        ready;
    logic [4:0]  cur_day;
    logic [3:0]  cur_month;
    logic [15:0] cur_year;
    logic        is_leap;

    modport source (output valid, cur_day, cur_month, cur_year, is_leap, input ready);
    modport sink   (input valid, cur_day, cur_month, cur_year, is_leap, output ready);
endinterface

@@ hdl/cdc_ctrl.sv @@
// Controller FSM of the calendar date counter.
// Depends on cdc_pkg (states, command and status structs).
module cdc_ctrl (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_in_valid,
    input  logic            i_opcode,
    output logic            o_in_ready,
    input  cdc_pkg::t_status i_status,
    output cdc_pkg::t_cmd   o_cmd
);

    cdc_pkg::t_state r_state;
    cdc_pkg::t_state n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= cdc_pkg::ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            cdc_pkg::ST_IDLE: begin
                if (i_in_valid) begin
                    n_state = (i_opcode == cdc_pkg::OP_LOAD) ? cdc_pkg::ST_DIV
                                                             : cdc_pkg::ST_ADV;
                end
            end
            cdc_pkg::ST_DIV: begin
                if (i_status.div_last) n_state = cdc_pkg::ST_CLAMP;
            end
            cdc_pkg::ST_CLAMP: n_state = cdc_pkg::ST_DONE;
            cdc_pkg::ST_ADV: begin
                if (i_status.cnt_zero) n_state = cdc_pkg::ST_DONE;
            end
            cdc_pkg::ST_DONE: begin
                if (i_status.out_free) n_state = cdc_pkg::ST_IDLE;
            end
            default: n_state = cdc_pkg::ST_IDLE;
        endcase
    end

    always_comb begin
        o_in_ready = 1'b0;
        o_cmd      = '0;
        unique case (r_state)
            cdc_pkg::ST_IDLE: begin
                o_in_ready       = 1'b1;
                o_cmd.ld_accept  = i_in_valid && (i_opcode == cdc_pkg::OP_LOAD);
                o_cmd.adv_accept = i_in_valid && (i_opcode == cdc_pkg::OP_ADVANCE);
            end
            cdc_pkg::ST_DIV:   o_cmd.div_step = 1'b1;
            cdc_pkg::ST_CLAMP: o_cmd.clamp    = 1'b1;
            cdc_pkg::ST_ADV:   o_cmd.adv_step = !i_status.cnt_zero;
            cdc_pkg::ST_DONE:  o_cmd.capture  = i_status.out_free;
            default: ;
        endcase
    end

endmodule

@@ hdl/cdc_dpath.sv @@
// Datapath of the calendar date counter: date registers, year mod-400
// tracking, reciprocal-multiply mod-100 unit, day stepper and
// output register. Depends on cdc_pkg.
module cdc_dpath #(
    parameter int YEAR_BITS  = 16,
    parameter int COUNT_BITS = 10
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  cdc_pkg::t_cmd    i_cmd,
    output cdc_pkg::t_status o_status,
    input  logic [7:0]       i_load_day,
    input  logic [7:0]       i_load_month,
    input  logic [15:0]      i_load_year,
    input  logic [9:0]       i_day_count,
    input  logic             i_out_ready,
    output logic             o_out_valid,
    output logic [4:0]       o_cur_day,
    output logic [3:0]       o_cur_month,
    output logic [15:0]      o_cur_year,
    output logic             o_is_leap
);

    // date state
    logic [4:0]            r_day;
    logic [3:0]            r_month;
    logic [YEAR_BITS-1:0]  r_year;
    logic [6:0]            r_mod100;   // year mod 100
    logic [1:0]            r_cent;     // (year / 100) mod 4
    // load staging and mod-100 unit
    logic [7:0]            r_ld_day;
    logic [6:0]            r_div_q;    // low bits of year / 100
    logic                  r_div_cnt;  // 1: quotient step pending
    logic [COUNT_BITS-1:0] r_count;
    // output word
    logic                  r_out_valid;
    logic [4:0]            r_o_day;
    logic [3:0]            r_o_month;
    logic [15:0]           r_o_year;
    logic                  r_o_leap;

    logic [YEAR_BITS+15:0]  w_year_in;
    logic [YEAR_BITS+15:0]  w_year_out;
    logic [YEAR_BITS+31:0]  w_year_ext;
    logic [COUNT_BITS+9:0]  w_count_in;
    logic [3:0]             w_month_clamp;
    logic                   w_leap;
    logic [4:0]             w_dim;
    logic [31:0]            w_div_y;
    logic [63:0]            w_div_prod;
    logic [6:0]             w_div_q;
    logic [13:0]            w_q_x100;
    logic [6:0]             w_mod_calc;
    logic [4:0]             w_day_clamp;

    assign w_year_in  = {{16{1'b0}}, i_load_year};
    assign w_year_out = {{16{1'b0}}, r_year};
    assign w_year_ext = {32'd0, r_year};
    assign w_count_in = {{COUNT_BITS{1'b0}}, i_day_count};

    always_comb begin
        if (i_load_month == 8'd0) begin
            w_month_clamp = cdc_pkg::MONTH_FIRST;
        end else if (i_load_month > {4'd0, cdc_pkg::MONTHS}) begin
            w_month_clamp = cdc_pkg::MONTHS;
        end else begin
            w_month_clamp = i_load_month[3:0];
        end
    end

    // leap: div by 4 and not by 100, or div by 400
    assign w_leap = ((r_year[1:0] == 2'd0) && (r_mod100 != 7'd0))
                 || ((r_mod100 == 7'd0) && (r_cent == 2'd0));
    assign w_dim  = cdc_pkg::days_in(r_month, w_leap);

    // step 1: quotient by reciprocal multiply; step 2: remainder from its low bits
    assign w_div_y    = w_year_ext[31:0];
    assign w_div_prod = {32'd0, w_div_y} * {32'd0, cdc_pkg::DIV100_MAGIC};
    assign w_div_q    = w_div_prod[cdc_pkg::DIV100_SHIFT +: 7];
    assign w_q_x100   = {7'd0, r_div_q} * {6'd0, cdc_pkg::CENTURY};
    assign w_mod_calc = w_div_y[6:0] - w_q_x100[6:0];

    always_comb begin
        if ({3'd0, w_dim} < r_ld_day) begin
            w_day_clamp = w_dim;
        end else if (r_ld_day == 8'd0) begin
            w_day_clamp = cdc_pkg::DAY_FIRST;
        end else begin
            w_day_clamp = r_ld_day[4:0];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_day    <= cdc_pkg::DAY_FIRST;
            r_month  <= cdc_pkg::MONTH_FIRST;
            r_year   <= YEAR_BITS'(cdc_pkg::YEAR_RESET);
            r_mod100 <= cdc_pkg::MOD_RESET;
            r_cent   <= cdc_pkg::CENT_RESET;
        end else begin
            if (i_cmd.ld_accept) begin
                r_year  <= w_year_in[YEAR_BITS-1:0];
                r_month <= w_month_clamp;
            end
            if (i_cmd.div_step && (r_div_cnt == 1'b0)) begin
                r_mod100 <= w_mod_calc;
                r_cent   <= r_div_q[1:0];
            end
            if (i_cmd.clamp) begin
                r_day <= w_day_clamp;
            end
            if (i_cmd.adv_step) begin
                if (r_day >= w_dim) begin
                    r_day <= cdc_pkg::DAY_FIRST;
                    if (r_month >= cdc_pkg::MONTHS) begin
                        r_month <= cdc_pkg::MONTH_FIRST;
                        if (r_year == '1) begin
                            r_year   <= '0;
                            r_mod100 <= '0;
                            r_cent   <= '0;
                        end else begin
                            r_year <= r_year + 1'b1;
                            if (r_mod100 == cdc_pkg::CENT_LAST) begin
                                r_mod100 <= '0;
                                r_cent   <= r_cent + 1'b1;
                            end else begin
                                r_mod100 <= r_mod100 + 1'b1;
                            end
                        end
                    end else begin
                        r_month <= r_month + 1'b1;
                    end
                end else begin
                    r_day <= r_day + 1'b1;
                end
            end
        end
    end

    // staging registers, no reset needed
    always_ff @(posedge i_clk) begin
        if (i_cmd.ld_accept) begin
            r_ld_day  <= i_load_day;
            r_div_cnt <= 1'b1;
        end else if (i_cmd.div_step) begin
            r_div_q   <= w_div_q;
            r_div_cnt <= r_div_cnt - 1'b1;
        end
        if (i_cmd.adv_accept) begin
            r_count <= w_count_in[COUNT_BITS-1:0];
        end else if (i_cmd.adv_step) begin
            r_count <= r_count - 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (i_cmd.capture) begin
            r_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.capture) begin
            r_o_day   <= r_day;
            r_o_month <= r_month;
            r_o_year  <= w_year_out[15:0];
            r_o_leap  <= w_leap;
        end
    end

    assign o_status.div_last = (r_div_cnt == 1'b0);
    assign o_status.cnt_zero = (r_count == '0);
    assign o_status.out_free = !r_out_valid || i_out_ready;

    assign o_out_valid = r_out_valid;
    assign o_cur_day   = r_o_day;
    assign o_cur_month = r_o_month;
    assign o_cur_year  = r_o_year;
    assign o_is_leap   = r_o_leap;

endmodule

@@ hdl/calendar_date_counter_top.sv @@
// Top level of the calendar date counter: FSM controller plus datapath.
// Depends on cdc_pkg, cdc_if (cdc_in_if, cdc_out_if), cdc_ctrl, cdc_dpath.
//
//  channel | dir | modport | payload
//  --------+-----+---------+-----------------------------------------------
//  i_in    | in  | sink    | opcode, load_day, load_month, load_year, day_count
//  o_out   | out | source  | cur_day, cur_month, cur_year, is_leap
//
// One command word at a time. An advance steps the date day_count times from
// accept to result: the day stepper moves one day per cycle.
// A load runs in steps: a reciprocal multiply gives year / 100, the next
// cycle forms year mod 100 for leap-year tracking, then the day is clamped.
// Reset (synchronous, active low) sets 1/1/2000 and empties the output word.
// A stalled output word holds; the next command is taken while it waits, and
// the controller holds in its final state until the output slot frees.
module calendar_date_counter_top #(
    parameter int YEAR_BITS  = 16,
    parameter int COUNT_BITS = 10
) (
    input  logic      i_clk,
    input  logic      i_rst_n,
    cdc_in_if.sink    i_in,
    cdc_out_if.source o_out
);

    cdc_pkg::t_cmd    w_cmd;
    cdc_pkg::t_status w_status;

    cdc_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in.valid),
        .i_opcode   (i_in.opcode),
        .o_in_ready (i_in.ready),
        .i_status   (w_status),
        .o_cmd      (w_cmd)
    );

    cdc_dpath #(
        .YEAR_BITS  (YEAR_BITS),
        .COUNT_BITS (COUNT_BITS)
    ) u_dpath (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cmd        (w_cmd),
        .o_status     (w_status),
        .i_load_day   (i_in.load_day),
        .i_load_month (i_in.load_month),
        .i_load_year  (i_in.load_year),
        .i_day_count  (i_in.day_count),
        .i_out_ready  (o_out.ready),
        .o_out_valid  (o_out.valid),
        .o_cur_day    (o_out.cur_day),
        .o_cur_month  (o_out.cur_month),
        .o_cur_year   (o_out.cur_year),
        .o_is_leap    (o_out.is_leap)
    );

endmodule

@@ hdl/cdc_chk.sv @@
// Port-level checks for the calendar date counter, bound to the top level.
// Depends on calendar_date_counter_top.
module cdc_chk (
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        i_in_valid,
    input logic        i_in_ready,
    input logic        i_out_valid,
    input logic        i_out_ready,
    input logic [4:0]  i_cur_day,
    input logic [3:0]  i_cur_month,
    input logic [15:0] i_cur_year,
    input logic        i_is_leap
);

    // one command in flight: ready drops right after an accept
    a_one_in_flight: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_in_valid && i_in_ready) |=> !i_in_ready)
        else $error("second command word accepted back to back");

    // output word stays put while stalled
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_out_valid && !i_out_ready) |=> (i_out_valid && $stable(i_cur_day)
            && $stable(i_cur_month) && $stable(i_cur_year) && $stable(i_is_leap)))
        else $error("stalled output word changed");

    a_date_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid |-> (i_cur_day >= 5'd1 && i_cur_month >= 4'd1
            && i_cur_month <= 4'd12))
        else $error("date out of range");

    a_leap_mod4: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_out_valid && (i_cur_year[1:0] != 2'd0)) |-> !i_is_leap)
        else $error("leap flag set for year not divisible by 4");

    a_feb_len: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_out_valid && i_cur_month == 4'd2) |->
            (i_is_leap ? (i_cur_day <= 5'd29) : (i_cur_day <= 5'd28)))
        else $error("February day beyond month length");

endmodule

bind calendar_date_counter_top cdc_chk u_cdc_chk (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .i_in_valid  (i_in.valid),
    .i_in_ready  (i_in.ready),
    .i_out_valid (o_out.valid),
    .i_out_ready (o_out.ready),
    .i_cur_day   (o_out.cur_day),
    .i_cur_month (o_out.cur_month),
    .i_cur_year  (o_out.cur_year),
    .i_is_leap   (o_out.is_leap)
);
